// File: src/tfpr_pkg.sv
// Shared constants and types for the frequency-to-prescaler block.
// No dependencies.
`timescale 1ns / 1ps
package tfpr_pkg;
    localparam int unsigned COUNTER_BITS_DEF = 16;
    localparam logic [31:0] CLOCK_RESET = 32'd240000000;
    localparam logic [16:0] PSC_LIMIT = 17'd65535;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_RANGE = 2'd1;
    localparam logic [1:0] ERR_NOFIT = 2'd2;

    // request classified by the front end
    typedef struct packed {
        logic [31:0] freq;
        logic [31:0] clk;
        logic        bad_range;
    } req_t;
endpackage

// File: src/tfpr_front.sv
// Front end: accepts requests, snapshots the clock register, flags range errors.
// Depends on tfpr_pkg.
`timescale 1ns / 1ps
module tfpr_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [31:0]          s_freq_hz,
    input  logic                 s_range_check,
    input  logic [31:0]          clk_hz,
    output logic                 q_valid,
    input  logic                 q_ready,
    output tfpr_pkg::req_t       q_data
);
    // two-entry queue between front and back
    tfpr_pkg::req_t mem_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       wp_reg, rp_reg;
    tfpr_pkg::req_t req;
    logic push, pop;

    always_comb begin
        req.freq = s_freq_hz;
        req.clk = clk_hz;
        req.bad_range = (s_freq_hz == 32'd0) ||
                        (s_range_check && (s_freq_hz > {1'b0, clk_hz[31:1]}));
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign push = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop = q_valid && q_ready;
    assign q_data = mem_reg[rp_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) cnt_next = cnt_reg + 2'd1;
        else if (pop && !push) cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
        end
        if (push) mem_reg[wp_reg] <= req;
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3) else $error("queue count overflow");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd2) |-> !s_ready) else $error("accept into full queue");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 2'd1)) else $error("count slip");
endmodule

// File: src/tfpr_div.sv
// Restoring divider: 32-bit dividend by 64-bit divisor, one quotient bit a cycle.
// No dependencies.
`timescale 1ns / 1ps
module tfpr_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [63:0] divisor,
    output logic        busy,
    output logic [31:0] quotient
);
    logic [63:0] rem_reg;
    logic [31:0] quo_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] dsr_reg;
    logic        busy_reg;
    logic [64:0] trial;

    assign trial = {rem_reg, quo_reg[31]} - {1'b0, dsr_reg};
    assign busy = busy_reg;
    assign quotient = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg <= 6'd0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg <= 6'd0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 6'd1;
            if (cnt_reg == 6'd31) busy_reg <= 1'b0;
        end
        if (start) begin
            rem_reg <= 64'd0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            if (!trial[64]) begin
                rem_reg <= trial[63:0];
                quo_reg <= {quo_reg[30:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[62:0], quo_reg[31]};
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
    end
endmodule

// File: src/tfpr_back.sv
// Back end: sequences divisions to find prescaler and reload, holds the result.
// Depends on tfpr_pkg and tfpr_div.
`timescale 1ns / 1ps
module tfpr_back #(
    parameter int unsigned COUNTER_BITS = tfpr_pkg::COUNTER_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  tfpr_pkg::req_t       q_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [15:0]          m_prescaler,
    output logic [15:0]          m_reload,
    output logic [1:0]           m_error_code
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_Q    = 3'd1;
    localparam logic [2:0] ST_BASE = 3'd2;
    localparam logic [2:0] ST_REL  = 3'd3;
    localparam logic [2:0] ST_REL2 = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;
    localparam logic [32:0] CMAX = 33'((64'd1 << COUNTER_BITS) - 64'd1);

    logic [2:0]  st_reg, st_next;
    logic [31:0] f_reg, clk_reg;
    logic [16:0] psc_reg;
    logic        wait_reg;
    logic [15:0] res_r_reg;
    logic [1:0]  res_e_reg;
    logic        out_v_reg;
    logic [15:0] out_p_reg, out_r_reg;
    logic [1:0]  out_e_reg;

    logic        d_start, d_busy;
    logic [31:0] d_quo;
    logic [63:0] d_div;
    logic [31:0] qm1;
    logic [63:0] fmul;

    tfpr_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(d_start),
        .dividend(clk_reg), .divisor(d_div), .busy(d_busy), .quotient(d_quo)
    );

    assign qm1 = d_quo - 32'd1;
    assign fmul = {32'd0, f_reg} * {47'd0, psc_reg};
    assign q_ready = (st_reg == ST_IDLE);
    assign m_valid = out_v_reg;
    assign m_prescaler = out_p_reg;
    assign m_reload = out_r_reg;
    assign m_error_code = out_e_reg;

    logic done;
    assign done = wait_reg && !d_busy;

    // hand the finished request to the output register once it is free
    logic load_out;
    assign load_out = (st_reg == ST_OUT) && (!out_v_reg || m_ready);

    always_comb begin
        d_start = 1'b0;
        d_div = 64'd0;
        st_next = st_reg;
        case (st_reg)
            ST_Q: if (!wait_reg) begin
                d_start = 1'b1;
                d_div = {32'd0, f_reg};
            end
            ST_BASE: if (!wait_reg) begin
                d_start = 1'b1;
                d_div = {f_reg, 32'd0} >> (32 - COUNTER_BITS);
            end
            ST_REL, ST_REL2: if (!wait_reg) begin
                d_start = 1'b1;
                d_div = fmul;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
            wait_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            if (load_out) out_v_reg <= 1'b1;
            else if (out_v_reg && m_ready) out_v_reg <= 1'b0;
            if (d_start) wait_reg <= 1'b1;
            else if (done) wait_reg <= 1'b0;
            case (st_reg)
                ST_IDLE: if (q_valid && q_ready) begin
                    f_reg <= q_data.freq;
                    clk_reg <= q_data.clk;
                    if (q_data.bad_range) begin
                        st_reg <= ST_OUT;
                        res_e_reg <= tfpr_pkg::ERR_RANGE;
                    end else st_reg <= ST_Q;
                end
                ST_Q: if (done) begin
                    if (d_quo < 32'd2) begin
                        res_e_reg <= tfpr_pkg::ERR_NOFIT; st_reg <= ST_OUT;
                    end else if ({1'b0, qm1} <= CMAX) begin
                        res_e_reg <= tfpr_pkg::ERR_NONE; psc_reg <= 17'd0;
                        res_r_reg <= qm1[15:0]; st_reg <= ST_OUT;
                    end else st_reg <= ST_BASE;
                end
                ST_BASE: if (done) begin
                    if (d_quo == 32'd0 || {1'b0, qm1} > {16'd0, tfpr_pkg::PSC_LIMIT}) begin
                        res_e_reg <= tfpr_pkg::ERR_NOFIT; st_reg <= ST_OUT;
                    end else begin
                        psc_reg <= d_quo[16:0]; st_reg <= ST_REL;
                    end
                end
                ST_REL: if (done) begin
                    if (d_quo == 32'd0) begin
                        res_e_reg <= tfpr_pkg::ERR_NOFIT; st_reg <= ST_OUT;
                    end else if ({1'b0, qm1} > CMAX) begin
                        if (psc_reg > tfpr_pkg::PSC_LIMIT) begin
                            res_e_reg <= tfpr_pkg::ERR_NOFIT; st_reg <= ST_OUT;
                        end else begin
                            psc_reg <= psc_reg + 17'd1; st_reg <= ST_REL2;
                        end
                    end else begin
                        res_e_reg <= tfpr_pkg::ERR_NONE;
                        psc_reg <= psc_reg - 17'd1;
                        res_r_reg <= qm1[15:0]; st_reg <= ST_OUT;
                    end
                end
                ST_REL2: if (done) begin
                    if (d_quo == 32'd0 || {1'b0, qm1} > CMAX) begin
                        res_e_reg <= tfpr_pkg::ERR_NOFIT; st_reg <= ST_OUT;
                    end else begin
                        res_e_reg <= tfpr_pkg::ERR_NONE;
                        psc_reg <= psc_reg - 17'd1;
                        res_r_reg <= qm1[15:0]; st_reg <= ST_OUT;
                    end
                end
                ST_OUT: if (load_out) begin
                    out_e_reg <= res_e_reg;
                    if (res_e_reg == tfpr_pkg::ERR_NONE) begin
                        out_p_reg <= psc_reg[15:0]; out_r_reg <= res_r_reg;
                    end else begin
                        out_p_reg <= 16'd0; out_r_reg <= 16'd0;
                    end
                    st_reg <= ST_IDLE;
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        d_start |-> !d_busy) else $error("divider restarted while busy");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_OUT) |=> out_v_reg) else $error("result not raised");
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_v_reg |-> (out_e_reg != 2'd3)) else $error("bad error code");
endmodule

// File: src/timer_freq_to_prescaler_reload.sv
// Top level of the frequency-to-prescaler/reload calculator.
// Depends on tfpr_pkg, tfpr_front, tfpr_back.
//
// Usage:
//   Write timer_clock_hz through cfg_we/cfg_wdata while idle (reset: 240 MHz).
//   Present a request on s_valid/s_ready with s_freq_hz and s_range_check.
//   One result per request comes out on m_valid/m_ready: m_prescaler,
//   m_reload and m_error_code (0 ok, 1 out of range, 2 no fit).
//   The front end snapshots the clock register with each request and parks
//   it in a two-entry queue; the back end runs a one-bit-per-cycle 32-step
//   divider up to four times per request. Range errors skip the divider;
//   any other request takes one, two, three or four divisions. The back end
//   works on one request at a time and takes the next from the queue only
//   once the last has gone to the output register.
//   A stalled receiver holds the result; the back end finishes one more
//   request and the queue takes up to two more. Reset clears the queue and
//   drops any pending result.
`timescale 1ns / 1ps
module timer_freq_to_prescaler_reload #(
    parameter int unsigned COUNTER_BITS = tfpr_pkg::COUNTER_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_freq_hz,
    input  logic        s_range_check,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_prescaler,
    output logic [15:0] m_reload,
    output logic [1:0]  m_error_code
);
    logic [31:0] clk_hz_reg;
    logic q_valid, q_ready;
    tfpr_pkg::req_t q_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) clk_hz_reg <= tfpr_pkg::CLOCK_RESET;
        else if (cfg_we) clk_hz_reg <= cfg_wdata;
    end

    tfpr_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_freq_hz(s_freq_hz), .s_range_check(s_range_check), .clk_hz(clk_hz_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
    );

    tfpr_back #(.COUNTER_BITS(COUNTER_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn), .q_valid(q_valid), .q_ready(q_ready),
        .q_data(q_data), .m_valid(m_valid), .m_ready(m_ready),
        .m_prescaler(m_prescaler), .m_reload(m_reload), .m_error_code(m_error_code)
    );
endmodule

// File: tb/sv/tfpr_checker.sv
// Checker for the frequency-to-prescaler/reload block: watches both channels,
// predicts each result from the request and the shadowed clock register.
// Depends on tfpr_pkg.
`timescale 1ns / 1ps
module tfpr_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [31:0] s_freq_hz,
    input  logic        s_range_check,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [15:0] m_prescaler,
    input  logic [15:0] m_reload,
    input  logic [1:0]  m_error_code,
    output int          fail_count,
    output int          pending
);
    typedef struct packed {
        logic [15:0] psc;
        logic [15:0] rel;
        logic [1:0]  err;
    } timing_t;

    localparam logic [63:0] CNT_MAX = 64'hFFFF;

    logic [31:0] clock_hz;
    timing_t     timing_q[$];

    assign pending = timing_q.size();

    function automatic timing_t solve_timing(logic [31:0] fr, logic chk, logic [31:0] ck);
        logic [63:0] f, c, q, base, psc, rel;
        timing_t     r;
        f = {32'd0, fr};
        c = {32'd0, ck};
        r = '{psc: 16'd0, rel: 16'd0, err: tfpr_pkg::ERR_NOFIT};
        if (f == 0 || (chk && f > c / 2)) begin
            r.err = tfpr_pkg::ERR_RANGE;
            return r;
        end
        q = c / f;
        if (q < 2) return r;
        if (q - 1 <= CNT_MAX) begin
            r = '{psc: 16'd0, rel: q[15:0] - 16'd1, err: tfpr_pkg::ERR_NONE};
            return r;
        end
        base = c / (f * (CNT_MAX + 1));
        if (base == 0 || base - 1 > 64'(tfpr_pkg::PSC_LIMIT)) return r;
        psc = base - 1;
        rel = c / (f * (psc + 1));
        if (rel == 0) return r;
        rel = rel - 1;
        if (rel > CNT_MAX) begin
            psc = psc + 1;
            if (psc > 64'(tfpr_pkg::PSC_LIMIT)) return r;
            rel = c / (f * (psc + 1));
            if (rel == 0 || rel - 1 > CNT_MAX) return r;
            rel = rel - 1;
        end
        r = '{psc: psc[15:0], rel: rel[15:0], err: tfpr_pkg::ERR_NONE};
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    initial fail_count = 0;

    always @(posedge aclk) begin
        timing_t w;
        if (!aresetn) begin
            clock_hz <= tfpr_pkg::CLOCK_RESET;
            timing_q.delete();
        end else begin
            if (cfg_we) clock_hz <= cfg_wdata;
            if (s_valid && s_ready)
                timing_q.push_back(solve_timing(s_freq_hz, s_range_check, clock_hz));
            if (m_valid && m_ready) begin
                if (timing_q.size() == 0) begin
                    report("unexpected result", 32'd0, 32'd0);
                end else begin
                    w = timing_q.pop_front();
                    if (m_prescaler !== w.psc)
                        report("prescaler", 32'(m_prescaler), 32'(w.psc));
                    if (m_reload !== w.rel)
                        report("reload", 32'(m_reload), 32'(w.rel));
                    if (m_error_code !== w.err)
                        report("error_code", 32'(m_error_code), 32'(w.err));
                end
            end
        end
    end
endmodule

// File: tb/sv/tb.sv
// Testbench top: clock, reset, request stimulus, receiver stalls and verdict.
// Depends on tfpr_pkg, timer_freq_to_prescaler_reload, tfpr_checker.
`timescale 1ns / 1ps
module tb;
    localparam int WATCHDOG = 20000;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_we = 0;
    logic [31:0] cfg_wdata = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [31:0] s_freq_hz = 0;
    logic        s_range_check = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [15:0] m_prescaler, m_reload;
    logic [1:0]  m_error_code;
    int          fail_count, pending, idle_cycles;
    logic        hold_off = 0;
    logic [31:0] clock_hz = tfpr_pkg::CLOCK_RESET;

    timer_freq_to_prescaler_reload uut (.*);

    tfpr_checker chk (.*);

    initial forever #2 aclk = ~aclk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // frequencies from random ranges or near the interesting boundaries of the clock
    function automatic logic [31:0] pick_freq(logic [31:0] ck);
        logic [63:0] d;
        case ($urandom_range(0, 7))
            0: return $urandom();
            1: return $urandom_range(1, 100);
            2: return $urandom_range(1, 5000);
            3: begin
                d = 64'(ck) / 65536;
                return 32'(d) + $urandom_range(0, 4) - 2;
            end
            4: begin
                d = 64'(ck) / (64'd65536 * 65536);
                return 32'(d) + $urandom_range(0, 2);
            end
            5: return ck / 2 + $urandom_range(0, 4) - 2;
            6: return ck - $urandom_range(0, 2);
            default: return $urandom_range(1, 200000);
        endcase
    endfunction

    // leaves valid high after the accept; the caller drops it before a gap
    task automatic send(logic [31:0] f, logic rc);
        s_valid <= 1;
        s_freq_hz <= f;
        s_range_check <= rc;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_gap(logic [31:0] f, logic rc);
        int g;
        send(f, rc);
        g = gap_len();
        if (g > 0) begin
            s_valid <= 0;
            repeat (g) @(posedge aclk);
        end
    endtask

    task automatic drain_and_set(logic [31:0] v);
        s_valid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (160) @(posedge aclk);
        cfg_we <= 1;
        cfg_wdata <= v;
        clock_hz = v;
        @(posedge aclk);
        cfg_we <= 0;
    endtask

    // receiver: random stalls, or a long hold while hold_off is set
    always @(posedge aclk) begin
        int n;
        if (hold_off) begin
            m_ready <= 0;
        end else if ($urandom_range(0, 99) < 60) begin
            m_ready <= 1;
        end else begin
            n = gap_len();
            m_ready <= 0;
            repeat (n) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        logic [31:0] clocks[6];
        idle_cycles = 0;
        clocks = '{32'd1000000, 32'hFFFFFFFF, 32'd240000000, 32'd72000000,
                   32'd1000003, 32'd4000000000};
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: extremes and both error codes at the reset clock
        send_gap(32'd0, 0);
        send_gap(32'd0, 1);
        send_gap(32'hFFFFFFFF, 0);
        send_gap(32'hFFFFFFFF, 1);
        send_gap(clock_hz / 2, 1);
        send_gap(clock_hz / 2 + 1, 1);
        send_gap(clock_hz / 2 + 1, 0);
        send_gap(clock_hz, 0);
        send_gap(32'd1, 0);
        send_gap(32'd1, 1);
        send_gap(clock_hz / 65536, 0);
        send_gap(clock_hz / 65536 + 1, 0);
        send_gap(32'd3662, 0);
        send_gap(32'd1000, 1);
        send_gap(32'hAAAAAAAA, 0);
        send_gap(32'h55555555, 0);

        // long receiver hold while requests keep coming
        hold_off <= 1;
        fork
            begin
                repeat (300) @(posedge aclk);
                hold_off <= 0;
            end
            for (int i = 0; i < 6; i++) send(pick_freq(clock_hz), $urandom_range(0, 1));
        join

        for (int p = 0; p < 6; p++) begin
            drain_and_set(clocks[p]);
            send_gap(32'd1, 0);
            send_gap(clock_hz / 2, 1);
            for (int i = 0; i < 126; i++) begin
                send_gap(pick_freq(clock_hz), $urandom_range(0, 1));
                // midway through each clock setting, a stretch with no idling
                if (i == 60)
                    for (int k = 0; k < 10; k++)
                        send(pick_freq(clock_hz), $urandom_range(0, 1));
            end
        end

        s_valid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (fail_count == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end
endmodule

// File: files.f
src/tfpr_pkg.sv
src/tfpr_front.sv
src/tfpr_div.sv
src/tfpr_back.sv
src/timer_freq_to_prescaler_reload.sv
tb/sv/tfpr_checker.sv
tb/sv/tb.sv
